### design/dual_receiver_link_selector_core_macros.svh
// Assertion macros for the dual receiver link selector.
// Sampled on clk and disabled while rst_n is low; no other dependencies.
`ifndef DUAL_RECEIVER_LINK_SELECTOR_CORE_MACROS_SVH
`define DUAL_RECEIVER_LINK_SELECTOR_CORE_MACROS_SVH

// Same-cycle implication.
`define DRLS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("drls assertion failed");

// Next-cycle implication.
`define DRLS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("drls assertion failed");

`endif

### design/drls_pkg.sv
// Shared types and constants for the dual receiver link selector.
// Used by the channel interfaces and the core; depends on nothing.
`default_nettype none

package drls_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_OFF   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STALE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECIDE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WEAK_RSSI  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GOOD_RSSI  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WEAK_LQ    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_GOOD_LQ    = 3'd6;

  localparam logic [15:0]        HOLD_OFF_RST  = 16'd200;
  localparam logic [15:0]        STALE_RST     = 16'd500;
  localparam logic [15:0]        DECIDE_RST    = 16'd50;
  localparam logic signed [7:0]  WEAK_RSSI_RST = -8'sd95;
  localparam logic signed [7:0]  GOOD_RSSI_RST = -8'sd85;
  localparam logic [6:0]         WEAK_LQ_RST   = 7'd30;
  localparam logic [6:0]         GOOD_LQ_RST   = 7'd50;

  localparam logic signed [7:0]  RSSI_FLOOR    = -8'sd128;

  typedef enum logic [1:0] {
    REQ_UPDATE    = 2'd0,
    REQ_FORCE_PRI = 2'd1,
    REQ_FORCE_SEC = 2'd2,
    REQ_AUTO      = 2'd3
  } req_t;

  localparam logic [1:0] ST_NONE      = 2'd0;
  localparam logic [1:0] ST_WEAK      = 2'd1;
  localparam logic [1:0] ST_GOOD      = 2'd2;
  localparam logic [1:0] ST_EXCELLENT = 2'd3;

  typedef struct packed {
    req_t        req_type;
    logic [31:0] now_ms;
    logic        pri_stats_valid;
    logic [7:0]  pri_rssi_mag;
    logic [6:0]  pri_link_quality;
    logic        pri_has_frames;
    logic        pri_has_rc;
    logic        sec_stats_valid;
    logic [7:0]  sec_rssi_mag;
    logic [6:0]  sec_link_quality;
    logic        sec_has_frames;
    logic        sec_has_rc;
  } in_word_t;

  typedef struct packed {
    logic        chosen_rx;
    logic        switched;
    logic [1:0]  pri_status;
    logic [1:0]  sec_status;
    logic        failsafe;
    logic [31:0] switch_total;
  } out_word_t;

endpackage

`default_nettype wire

### design/drls_intf.sv
// Valid/ready channel interfaces for the update words and the result words.
// Depends on drls_pkg for the word types.
`default_nettype none

interface drls_in_if;
  logic                valid;
  logic                ready;
  drls_pkg::in_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface drls_out_if;
  logic                valid;
  logic                ready;
  drls_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### design/dual_receiver_link_selector_core.sv
// Dual receiver link selector: grades two receivers from their link statistics
// and chooses the one that drives the outputs.
// Channels: in_ch takes one update or request word per handshake; out_ch gives
// one result word per input word, in order. The cfg_ port writes one register
// per cycle with cfg_we high and must only be used while the block is idle.
// An accepted word is captured in an input register, then one pass of
// compare-and-select logic updates the receiver state and loads the result
// register that drives out_ch.valid, when that register is free. Throughput
// is one word per cycle while out_ch.ready is high; the stored state is
// updated in the same pass that computes a word's result, so the next word
// sees it at once. When out_ch.ready is low the result register holds its
// word and the input register can still take one more word; in_ch.ready
// drops only when both are full. Reset (rst_n low at a clock edge) empties
// both registers, loads the register defaults, selects the primary receiver,
// sets failsafe and clears the statistics, timers and the switch count.
`default_nettype none

module dual_receiver_link_selector_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  drls_in_if.sink                                 in_ch,
  drls_out_if.source                              out_ch,
  input  wire logic                               cfg_we,
  input  wire logic [drls_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire logic [drls_pkg::CFG_DATA_W-1:0]    cfg_data
);

  `include "dual_receiver_link_selector_core_macros.svh"

  logic [15:0]        hold_off_r;
  logic [15:0]        stale_r;
  logic [15:0]        decide_r;
  logic signed [7:0]  weak_rssi_r;
  logic signed [7:0]  good_rssi_r;
  logic [6:0]         weak_lq_r;
  logic [6:0]         good_lq_r;

  logic               s1_valid_r;
  drls_pkg::in_word_t s1_data_r;
  logic               out_valid_r;
  drls_pkg::out_word_t out_data_r;
  drls_pkg::out_word_t out_data_nxt;
  logic               s1_adv;

  logic signed [7:0]  rssi_r [2];
  logic signed [7:0]  rssi_nxt [2];
  logic [6:0]         lq_r [2];
  logic [6:0]         lq_nxt [2];
  logic [31:0]        time_r [2];
  logic [31:0]        time_nxt [2];
  logic [1:0]         status_r [2];
  logic [1:0]         status_nxt [2];
  logic               active_r;
  logic               active_nxt;
  logic [31:0]        last_sw_r;
  logic [31:0]        last_sw_nxt;
  logic [31:0]        last_dec_r;
  logic [31:0]        last_dec_nxt;
  logic [31:0]        switch_cnt_r;
  logic [31:0]        switch_cnt_nxt;
  logic               failsafe_r;
  logic               failsafe_nxt;

  logic               rx_valid [2];
  logic [7:0]         rx_mag [2];
  logic [6:0]         rx_lq [2];
  logic               rx_frames [2];
  logic               rx_rc [2];
  logic signed [7:0]  upd_rssi [2];
  logic [6:0]         upd_lq [2];
  logic [31:0]        upd_time [2];
  logic [31:0]        age [2];
  logic [1:0]         grade [2];
  logic [31:0]        since_dec;
  logic [31:0]        since_sw;
  logic               due;
  logic               held;
  logic               next_sel;
  logic               sw;

  assign s1_adv       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  always_comb begin
    rx_valid[0]  = s1_data_r.pri_stats_valid;
    rx_mag[0]    = s1_data_r.pri_rssi_mag;
    rx_lq[0]     = s1_data_r.pri_link_quality;
    rx_frames[0] = s1_data_r.pri_has_frames;
    rx_rc[0]     = s1_data_r.pri_has_rc;
    rx_valid[1]  = s1_data_r.sec_stats_valid;
    rx_mag[1]    = s1_data_r.sec_rssi_mag;
    rx_lq[1]     = s1_data_r.sec_link_quality;
    rx_frames[1] = s1_data_r.sec_has_frames;
    rx_rc[1]     = s1_data_r.sec_has_rc;

    for (int r = 0; r < 2; r++) begin
      if (rx_valid[r]) begin
        upd_rssi[r] = rx_mag[r][7] ? drls_pkg::RSSI_FLOOR : $signed(8'd0 - rx_mag[r]);
        upd_lq[r]   = rx_lq[r];
        upd_time[r] = s1_data_r.now_ms;
      end else begin
        upd_rssi[r] = rssi_r[r];
        upd_lq[r]   = lq_r[r];
        upd_time[r] = time_r[r];
      end
      age[r] = s1_data_r.now_ms - upd_time[r];
      if ((age[r] > {16'd0, stale_r}) || !rx_frames[r]) begin
        grade[r] = drls_pkg::ST_NONE;
      end else if ((upd_rssi[r] <= weak_rssi_r) || (upd_lq[r] < weak_lq_r)) begin
        grade[r] = drls_pkg::ST_WEAK;
      end else if ((upd_rssi[r] <= good_rssi_r) || (upd_lq[r] < good_lq_r)) begin
        grade[r] = drls_pkg::ST_GOOD;
      end else begin
        grade[r] = drls_pkg::ST_EXCELLENT;
      end
    end

    since_dec = s1_data_r.now_ms - last_dec_r;
    since_sw  = s1_data_r.now_ms - last_sw_r;
    due       = since_dec >= {16'd0, decide_r};
    held      = since_sw < {16'd0, hold_off_r};
    next_sel  = active_r;
    if (due && !held) begin
      if (!active_r) begin
        if ((grade[0] < drls_pkg::ST_GOOD) && (grade[1] >= drls_pkg::ST_GOOD)) begin
          next_sel = 1'b1;
        end
      end else begin
        if ((grade[1] < drls_pkg::ST_GOOD) && (grade[0] > grade[1])) begin
          next_sel = 1'b0;
        end
      end
    end
    sw = next_sel != active_r;

    rssi_nxt       = rssi_r;
    lq_nxt         = lq_r;
    time_nxt       = time_r;
    status_nxt     = status_r;
    active_nxt     = active_r;
    last_sw_nxt    = last_sw_r;
    last_dec_nxt   = last_dec_r;
    switch_cnt_nxt = switch_cnt_r;
    failsafe_nxt   = failsafe_r;

    if (s1_adv) begin
      case (s1_data_r.req_type)
        drls_pkg::REQ_UPDATE: begin
          rssi_nxt   = upd_rssi;
          lq_nxt     = upd_lq;
          time_nxt   = upd_time;
          status_nxt = grade;
          if (due) begin
            last_dec_nxt = s1_data_r.now_ms;
          end
          if (sw) begin
            active_nxt     = next_sel;
            last_sw_nxt    = s1_data_r.now_ms;
            switch_cnt_nxt = switch_cnt_r + 32'd1;
          end
          failsafe_nxt = !rx_rc[next_sel];
        end
        drls_pkg::REQ_FORCE_PRI: begin
          active_nxt = 1'b0;
        end
        drls_pkg::REQ_FORCE_SEC: begin
          active_nxt = 1'b1;
        end
        drls_pkg::REQ_AUTO: begin
          active_nxt  = 1'b0;
          last_sw_nxt = 32'd0;
        end
        default: begin
          active_nxt = active_r;
        end
      endcase
    end

    out_data_nxt.chosen_rx    = active_nxt;
    out_data_nxt.switched     = (s1_data_r.req_type == drls_pkg::REQ_UPDATE) && sw;
    out_data_nxt.pri_status   = status_nxt[0];
    out_data_nxt.sec_status   = status_nxt[1];
    out_data_nxt.failsafe     = failsafe_nxt;
    out_data_nxt.switch_total = switch_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_off_r  <= drls_pkg::HOLD_OFF_RST;
      stale_r     <= drls_pkg::STALE_RST;
      decide_r    <= drls_pkg::DECIDE_RST;
      weak_rssi_r <= drls_pkg::WEAK_RSSI_RST;
      good_rssi_r <= drls_pkg::GOOD_RSSI_RST;
      weak_lq_r   <= drls_pkg::WEAK_LQ_RST;
      good_lq_r   <= drls_pkg::GOOD_LQ_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        drls_pkg::CFG_HOLD_OFF:  hold_off_r  <= cfg_data;
        drls_pkg::CFG_STALE:     stale_r     <= cfg_data;
        drls_pkg::CFG_DECIDE:    decide_r    <= cfg_data;
        drls_pkg::CFG_WEAK_RSSI: weak_rssi_r <= $signed(cfg_data[7:0]);
        drls_pkg::CFG_GOOD_RSSI: good_rssi_r <= $signed(cfg_data[7:0]);
        drls_pkg::CFG_WEAK_LQ:   weak_lq_r   <= cfg_data[6:0];
        drls_pkg::CFG_GOOD_LQ:   good_lq_r   <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int r = 0; r < 2; r++) begin
        rssi_r[r]   <= 8'sd0;
        lq_r[r]     <= 7'd0;
        time_r[r]   <= 32'd0;
        status_r[r] <= drls_pkg::ST_NONE;
      end
      active_r     <= 1'b0;
      last_sw_r    <= 32'd0;
      last_dec_r   <= 32'd0;
      switch_cnt_r <= 32'd0;
      failsafe_r   <= 1'b1;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      rssi_r       <= rssi_nxt;
      lq_r         <= lq_nxt;
      time_r       <= time_nxt;
      status_r     <= status_nxt;
      active_r     <= active_nxt;
      last_sw_r    <= last_sw_nxt;
      last_dec_r   <= last_dec_nxt;
      switch_cnt_r <= switch_cnt_nxt;
      failsafe_r   <= failsafe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_data_r <= in_ch.data;
    end
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  `DRLS_ASSERT_NEXT(a_switch_counts, s1_adv && out_data_nxt.switched,
                    switch_cnt_r == $past(switch_cnt_r) + 32'd1)
  `DRLS_ASSERT_NEXT(a_failsafe_held, s1_adv && (s1_data_r.req_type != drls_pkg::REQ_UPDATE),
                    $stable(failsafe_r) && $stable(switch_cnt_r))
  `DRLS_ASSERT_NEXT(a_auto_clears, s1_adv && (s1_data_r.req_type == drls_pkg::REQ_AUTO),
                    !active_r && (last_sw_r == 32'd0))
  `DRLS_ASSERT_NOW(a_result_matches, out_valid_r,
                   (out_data_r.chosen_rx == active_r) || s1_valid_r)

endmodule

`default_nettype wire
